FILE: design/srtm_pkg.sv
// Shared constants and types for the three-mode signed remainder block.
`timescale 1ns / 1ps
`default_nettype none
package srtm_pkg;

   // Default operand width
   localparam int CELL_BITS = 32;

   // Front-to-back queue depth, power of two
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [1:0] {
      MODE_FLOORED = 2'd0,
      MODE_EUCLID  = 2'd1,
      MODE_TRUNC   = 2'd2
   } mode_type;

   // Per-transaction side information carried alongside the magnitudes
   typedef struct packed {
      logic     kill;   // result forced to zero
      mode_type mode;
      logic     neg_y;
      logic     neg_x;
   } meta_type;

   localparam int META_BITS = $bits(meta_type);

endpackage
`default_nettype wire

FILE: design/srtm_if.sv
// Request and response channel interfaces with valid/ready handshake.
`timescale 1ns / 1ps
`default_nettype none
interface srtm_req_if #(
   parameter int CELL_BITS = srtm_pkg::CELL_BITS
);
   logic                        valid;
   logic                        ready;
   logic [1:0]                  action;
   logic signed [CELL_BITS-1:0] dividend;
   logic signed [CELL_BITS-1:0] divisor;

   modport source (output valid, output action, output dividend, output divisor,
                   input ready);
   modport sink (input valid, input action, input dividend, input divisor,
                 output ready);
endinterface

interface srtm_rsp_if #(
   parameter int CELL_BITS = srtm_pkg::CELL_BITS
);
   logic                        valid;
   logic                        ready;
   logic signed [CELL_BITS-1:0] remainder;

   modport source (output valid, output remainder, input ready);
   modport sink (input valid, input remainder, output ready);
endinterface
`default_nettype wire

FILE: design/signed_remainder_three_modes.sv
// Top level: signed remainder in floored, euclidean or truncated mode.
// A request passes the queue, the load stage, the divider stages, the sign fix-up register and the response register.
// Throughput: one transaction per cycle while the response is not held, set by the one-bit-per-stage divider pipeline.
// A two-entry queue keeps taking requests while the response is stalled, until both entries are full.
// Reset (synchronous) empties the queue and clears all pipeline valid bits; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module signed_remainder_three_modes #(
   parameter int CELL_BITS = srtm_pkg::CELL_BITS
) (
   input  logic        clock,
   input  logic        reset,
   srtm_req_if.sink    req_chan,
   srtm_rsp_if.source  rsp_chan
);

   localparam int ENTRY_BITS = srtm_pkg::META_BITS + 2 * CELL_BITS;

   logic                  push_valid;
   logic                  push_ready;
   logic [ENTRY_BITS-1:0] push_data;
   logic                  pop_valid;
   logic                  pop_ready;
   logic [ENTRY_BITS-1:0] pop_data;

   srtm_front #(
      .CELL_BITS  (CELL_BITS),
      .ENTRY_BITS (ENTRY_BITS)
   ) u_front (
      .req_chan   (req_chan),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   srtm_queue #(
      .ENTRY_BITS (ENTRY_BITS)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   srtm_back #(
      .CELL_BITS  (CELL_BITS),
      .ENTRY_BITS (ENTRY_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp_chan  (rsp_chan)
   );

endmodule
`default_nettype wire

FILE: design/srtm_front.sv
// Front end: takes request transactions, splits operands into sign and magnitude.
`timescale 1ns / 1ps
`default_nettype none
module srtm_front #(
   parameter int CELL_BITS   = srtm_pkg::CELL_BITS,
   parameter int ENTRY_BITS  = srtm_pkg::META_BITS + 2 * srtm_pkg::CELL_BITS
) (
   srtm_req_if.sink              req_chan,
   output logic                  push_valid,
   input  logic                  push_ready,
   output logic [ENTRY_BITS-1:0] push_data
);

   logic [CELL_BITS-1:0] dvd_bits;
   logic [CELL_BITS-1:0] dvs_bits;
   logic [CELL_BITS-1:0] mag_x;
   logic [CELL_BITS-1:0] mag_y;
   logic                 bad_mode;
   srtm_pkg::meta_type   meta;

   always_comb begin
      dvd_bits = req_chan.dividend;
      dvs_bits = req_chan.divisor;
      mag_x    = dvd_bits[CELL_BITS-1] ? ('0 - dvd_bits) : dvd_bits;
      mag_y    = dvs_bits[CELL_BITS-1] ? ('0 - dvs_bits) : dvs_bits;

      case (srtm_pkg::mode_type'(req_chan.action))
         srtm_pkg::MODE_FLOORED,
         srtm_pkg::MODE_EUCLID,
         srtm_pkg::MODE_TRUNC: begin
            bad_mode = 1'b0;
         end
         default: begin
            bad_mode = 1'b1;
         end
      endcase

      meta.mode  = srtm_pkg::mode_type'(req_chan.action);
      meta.neg_x = dvd_bits[CELL_BITS-1];
      meta.neg_y = dvs_bits[CELL_BITS-1];
      // zero divisor and divisor of minus one both give zero
      meta.kill  = bad_mode || (dvs_bits == '0) || (dvs_bits == '1);
   end

   assign push_valid     = req_chan.valid;
   assign req_chan.ready = push_ready;
   assign push_data      = {meta, mag_y, mag_x};

endmodule
`default_nettype wire

FILE: design/srtm_queue.sv
// Small register FIFO between the front end and the divider pipeline.
`timescale 1ns / 1ps
`default_nettype none
module srtm_queue #(
   parameter int ENTRY_BITS = srtm_pkg::META_BITS + 2 * srtm_pkg::CELL_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   output logic                  push_ready,
   input  logic [ENTRY_BITS-1:0] push_data,
   output logic                  pop_valid,
   input  logic                  pop_ready,
   output logic [ENTRY_BITS-1:0] pop_data
);

   localparam int DEPTH    = srtm_pkg::QUEUE_DEPTH;
   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   logic [ENTRY_BITS-1:0] entry_ff [DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic                  push;
   logic                  pop;

   always_comb begin
      push_ready = (count_ff != CNT_BITS'(DEPTH));
      pop_valid  = (count_ff != '0);
      push       = push_valid && push_ready;
      pop        = pop_valid && pop_ready;
      wr_ptr_in  = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in  = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      case ({push, pop})
         2'b10: begin
            count_in = count_ff + 1'b1;
         end
         2'b01: begin
            count_in = count_ff - 1'b1;
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   assign pop_data = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

FILE: design/srtm_back.sv
// Back end: bit-per-stage restoring divider, sign fix-up and response register.
`timescale 1ns / 1ps
`default_nettype none
module srtm_back #(
   parameter int CELL_BITS  = srtm_pkg::CELL_BITS,
   parameter int ENTRY_BITS = srtm_pkg::META_BITS + 2 * srtm_pkg::CELL_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  pop_valid,
   output logic                  pop_ready,
   input  logic [ENTRY_BITS-1:0] pop_data,
   srtm_rsp_if.source            rsp_chan
);

   localparam int STAGES = CELL_BITS;

   // Stage 0 is the load stage; stage STAGES holds the unsigned remainder.
   logic [STAGES:0]       vld_ff, vld_in;
   logic [CELL_BITS-1:0]  rem_ff  [STAGES+1];
   logic [CELL_BITS-1:0]  rem_in  [STAGES+1];
   logic [CELL_BITS-1:0]  div_ff  [STAGES+1];
   logic [CELL_BITS-1:0]  div_in  [STAGES+1];
   srtm_pkg::meta_type    meta_ff [STAGES+1];
   srtm_pkg::meta_type    meta_in [STAGES+1];
   logic [CELL_BITS-1:0]  dvd_ff  [STAGES];
   logic [CELL_BITS-1:0]  dvd_in  [STAGES];

   logic                  fix_vld_ff, fix_vld_in;
   logic [CELL_BITS-1:0]  fix_mag_ff, fix_mag_in;
   logic                  fix_neg_ff, fix_neg_in;
   logic                  fix_kill_ff, fix_kill_in;
   logic [CELL_BITS-1:0]  fix_diff;
   logic                  urem_nz;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [CELL_BITS-1:0]  rsp_rem_ff, rsp_rem_in;

   logic                  adv;

   // Whole back end moves together unless the response register is held.
   assign adv       = !rsp_valid_ff || rsp_chan.ready;
   assign pop_ready = adv;

   always_comb begin
      vld_in     = {vld_ff[STAGES-1:0], pop_valid};
      rem_in[0]  = '0;
      dvd_in[0]  = pop_data[CELL_BITS-1:0];
      div_in[0]  = pop_data[2*CELL_BITS-1:CELL_BITS];
      meta_in[0] = srtm_pkg::meta_type'(pop_data[ENTRY_BITS-1:2*CELL_BITS]);
   end

   for (genvar k = 0; k < STAGES; k++) begin : g_step
      logic [CELL_BITS:0] trial;
      logic [CELL_BITS:0] diff;

      always_comb begin
         trial = {rem_ff[k], dvd_ff[k][CELL_BITS-1]};
         diff  = trial - {1'b0, div_ff[k]};
         // borrow means the trial stays below the divisor
         rem_in[k+1]  = diff[CELL_BITS] ? trial[CELL_BITS-1:0] : diff[CELL_BITS-1:0];
         div_in[k+1]  = div_ff[k];
         meta_in[k+1] = meta_ff[k];
      end

      if (k < STAGES - 1) begin : g_shift
         always_comb begin
            dvd_in[k+1] = dvd_ff[k] << 1;
         end
      end
   end

   // Sign fix-up: pick |result| and its sign for the selected mode.
   always_comb begin
      urem_nz     = (rem_ff[STAGES] != '0);
      fix_diff    = div_ff[STAGES] - rem_ff[STAGES];
      fix_vld_in  = vld_ff[STAGES];
      fix_kill_in = meta_ff[STAGES].kill;
      case (meta_ff[STAGES].mode)
         srtm_pkg::MODE_FLOORED: begin
            if (urem_nz && (meta_ff[STAGES].neg_x != meta_ff[STAGES].neg_y)) begin
               fix_mag_in = fix_diff;
               fix_neg_in = meta_ff[STAGES].neg_y;
            end else begin
               fix_mag_in = rem_ff[STAGES];
               fix_neg_in = meta_ff[STAGES].neg_x;
            end
         end
         srtm_pkg::MODE_EUCLID: begin
            fix_mag_in = (urem_nz && meta_ff[STAGES].neg_x) ? fix_diff : rem_ff[STAGES];
            fix_neg_in = 1'b0;
         end
         default: begin
            fix_mag_in = rem_ff[STAGES];
            fix_neg_in = meta_ff[STAGES].neg_x;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = fix_vld_ff;
      if (fix_kill_ff) begin
         rsp_rem_in = '0;
      end else if (fix_neg_ff) begin
         rsp_rem_in = '0 - fix_mag_ff;
      end else begin
         rsp_rem_in = fix_mag_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         fix_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         vld_ff       <= vld_in;
         fix_vld_ff   <= fix_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int s = 0; s <= STAGES; s++) begin
            rem_ff[s]  <= rem_in[s];
            div_ff[s]  <= div_in[s];
            meta_ff[s] <= meta_in[s];
         end
         for (int s = 0; s < STAGES; s++) begin
            dvd_ff[s] <= dvd_in[s];
         end
         fix_mag_ff  <= fix_mag_in;
         fix_neg_ff  <= fix_neg_in;
         fix_kill_ff <= fix_kill_in;
         rsp_rem_ff  <= rsp_rem_in;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.remainder = rsp_rem_ff;

endmodule
`default_nettype wire

FILE: verif/testbench.sv
// Self-checking testbench for the three-mode signed remainder block.
`timescale 1ns / 1ps
module testbench;

   typedef logic signed [srtm_pkg::CELL_BITS-1:0] cell_type;

   localparam cell_type    CELL_MIN      = {1'b1, {(srtm_pkg::CELL_BITS-1){1'b0}}};
   localparam cell_type    CELL_MAX      = ~CELL_MIN;
   localparam logic [1:0]  ACTION_UNUSED = 2'd3;
   localparam int          DRAIN_CYCLES  = srtm_pkg::CELL_BITS + 16;
   localparam int          CYCLE_LIMIT   = 400000;
   localparam int          REPORT_LIMIT  = 10;

   typedef struct {
      logic [1:0] action;
      cell_type   dividend;
      cell_type   divisor;
      cell_type   remainder;
   } remainder_txn_type;

   logic clock;
   logic reset;

   srtm_req_if req_chan ();
   srtm_rsp_if rsp_chan ();

   signed_remainder_three_modes dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   remainder_txn_type expected_remainders[$];
   int                mismatch_count;
   int                cycle_count;
   int                sink_hold_cycles;
   int                sink_stall_left;
   bit                idling_on;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Remainder for the selected mode; zero for divisor 0 or -1 and the unused mode.
   function automatic cell_type predicted_remainder(logic [1:0] action, cell_type x,
                                                    cell_type y);
      longint sx;
      longint sy;
      longint r;
      sx = x;
      sy = y;
      if (sy == 0 || sy == -1) return '0;
      r = sx % sy;
      case (action)
         srtm_pkg::MODE_FLOORED: begin
            if (r != 0 && ((r < 0) != (sy < 0))) r += sy;
         end
         srtm_pkg::MODE_EUCLID: begin
            if (r < 0) r = (sy < 0) ? r - sy : r + sy;
         end
         srtm_pkg::MODE_TRUNC: begin
         end
         default: return '0;
      endcase
      return cell_type'(r);
   endfunction

   // Mostly short gaps, a few long ones.
   function automatic int random_gap();
      if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   function automatic cell_type random_operand();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: return cell_type'($urandom);
         5, 6, 7:       return cell_type'($signed($urandom_range(0, 40)) - 20);
         8: begin
            case ($urandom_range(0, 4))
               0: return CELL_MIN;
               1: return CELL_MAX;
               2: return '0;
               3: return '1;
               default: return cell_type'(1);
            endcase
         end
         default: return cell_type'($urandom) >>> $urandom_range(1, srtm_pkg::CELL_BITS - 1);
      endcase
   endfunction

   function automatic logic [1:0] random_action();
      if ($urandom_range(0, 15) == 0) return ACTION_UNUSED;
      return srtm_pkg::mode_type'($urandom_range(0, 2));
   endfunction

   task automatic send_request(logic [1:0] action, cell_type x, cell_type y);
      int gap;
      remainder_txn_type txn;
      gap = (idling_on && $urandom_range(0, 2) == 0) ? random_gap() : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid    <= 1'b1;
      req_chan.action   <= action;
      req_chan.dividend <= x;
      req_chan.divisor  <= y;
      do @(posedge clock); while (!req_chan.ready);
      txn.action    = action;
      txn.dividend  = x;
      txn.divisor   = y;
      txn.remainder = predicted_remainder(action, x, y);
      expected_remainders.push_back(txn);
   endtask

   task automatic wait_for_drain();
      while (expected_remainders.size() != 0) @(posedge clock);
   endtask

   task automatic test_sign_combinations();
      for (int m = 0; m <= 2; m++) begin
         send_request(srtm_pkg::mode_type'(m),  7,  2);
         send_request(srtm_pkg::mode_type'(m), -7,  2);
         send_request(srtm_pkg::mode_type'(m),  7, -2);
         send_request(srtm_pkg::mode_type'(m), -7, -2);
         send_request(srtm_pkg::mode_type'(m), -6,  3);
      end
   endtask

   task automatic test_special_divisors();
      send_request(srtm_pkg::MODE_FLOORED, CELL_MIN, -1);
      send_request(srtm_pkg::MODE_EUCLID,  5,        0);
      send_request(srtm_pkg::MODE_TRUNC,   CELL_MIN, 0);
      send_request(srtm_pkg::MODE_EUCLID,  123,      -1);
      send_request(ACTION_UNUSED,          -7,       2);
   endtask

   task automatic test_extremes();
      send_request(srtm_pkg::MODE_EUCLID,  -5,       CELL_MIN);
      send_request(srtm_pkg::MODE_FLOORED, CELL_MAX, CELL_MIN);
      send_request(srtm_pkg::MODE_TRUNC,   CELL_MIN, CELL_MAX);
      send_request(srtm_pkg::MODE_FLOORED, CELL_MIN, CELL_MIN);
      send_request(srtm_pkg::MODE_EUCLID,  CELL_MIN, 3);
   endtask

   task automatic test_random_traffic(int count);
      idling_on = 1'b1;
      repeat (count) send_request(random_action(), random_operand(), random_operand());
   endtask

   task automatic test_back_to_back(int count);
      idling_on = 1'b0;
      repeat (count) send_request(random_action(), random_operand(), random_operand());
      idling_on = 1'b1;
   endtask

   // Response side holds off long enough for the pipeline to fill and stall requests.
   task automatic test_backpressure();
      idling_on        = 1'b0;
      sink_hold_cycles = 300;
      repeat (60) send_request(random_action(), random_operand(), random_operand());
      idling_on = 1'b1;
      @(negedge clock) req_chan.valid <= 1'b0;
      wait_for_drain();
   endtask

   initial begin
      rsp_chan.ready  = 1'b0;
      sink_stall_left = 0;
      forever begin
         @(negedge clock);
         if (sink_hold_cycles > 0) begin
            rsp_chan.ready <= 1'b0;
            sink_hold_cycles--;
         end else if (sink_stall_left > 0) begin
            rsp_chan.ready <= 1'b0;
            sink_stall_left--;
         end else if (idling_on && $urandom_range(0, 3) == 0) begin
            rsp_chan.ready <= 1'b0;
            sink_stall_left = random_gap() - 1;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      remainder_txn_type txn;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_remainders.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("unexpected transaction: remainder %0d", rsp_chan.remainder);
         end else begin
            txn = expected_remainders.pop_front();
            if (rsp_chan.remainder !== txn.remainder) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("mismatch: action %0d %0d rem %0d: expected %0d, got %0d",
                           txn.action, txn.dividend, txn.divisor, txn.remainder,
                           rsp_chan.remainder);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[signed_remainder_three_modes] ERROR");
         $finish;
      end
   end

   initial begin
      clock             = 1'b0;
      reset             = 1'b1;
      req_chan.valid    = 1'b0;
      req_chan.action   = '0;
      req_chan.dividend = '0;
      req_chan.divisor  = '0;
      mismatch_count    = 0;
      cycle_count       = 0;
      sink_hold_cycles  = 0;
      idling_on         = 1'b1;
      repeat (7) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      test_sign_combinations();
      test_special_divisors();
      test_extremes();
      test_random_traffic(275);
      test_backpressure();
      test_back_to_back(150);
      test_random_traffic(40);

      @(negedge clock) req_chan.valid <= 1'b0;
      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_remainders.size() == 0) begin
         $display("[signed_remainder_three_modes] OK");
      end else begin
         $display("[signed_remainder_three_modes] ERROR");
      end
      $finish;
   end

endmodule
